// ===== hdl/hnhd_pkg.sv =====
// Package for the hand-near-head dwell detector.
// Holds window sizes, derived widths, register codes and reset values.
// No dependencies; used by hand_near_head_dwell_detector.
package hnhd_pkg;

  localparam int COORD_W = 10;
  localparam int DWELL_W = 8;
  localparam int LIMIT_W = 10;
  localparam int HOLD_W  = 8;

  localparam int X_WINDOW = 20;
  localparam int Y_WINDOW = 10;

  // Slot index widths; a one-entry window still gets one index bit.
  localparam int X_IDX_W = (X_WINDOW > 1) ? $clog2(X_WINDOW) : 1;
  localparam int Y_IDX_W = (Y_WINDOW > 1) ? $clog2(Y_WINDOW) : 1;
  localparam int X_CNT_W = $clog2(X_WINDOW + 1);
  localparam int Y_CNT_W = $clog2(Y_WINDOW + 1);
  localparam int X_SUM_W = $clog2(X_WINDOW * ((1 << COORD_W) - 1) + 1);
  localparam int Y_SUM_W = $clog2(Y_WINDOW * ((1 << COORD_W) - 1) + 1);
  localparam int X_PROD_W = LIMIT_W + X_CNT_W;
  localparam int Y_PROD_W = LIMIT_W + Y_CNT_W;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    REG_X_LIMIT = 2'd0,
    REG_Y_LIMIT = 2'd1,
    REG_X_HOLD  = 2'd2,
    REG_Y_HOLD  = 2'd3
  } reg_idx_t;

  localparam logic [LIMIT_W-1:0] X_LIMIT_RST = LIMIT_W'(30);
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RST = LIMIT_W'(30);
  localparam logic [HOLD_W-1:0]  X_HOLD_RST  = HOLD_W'(5);
  localparam logic [HOLD_W-1:0]  Y_HOLD_RST  = HOLD_W'(10);

  localparam logic [DWELL_W-1:0] DWELL_MAX = {DWELL_W{1'b1}};

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== hdl/hand_near_head_dwell_detector.sv =====
// Hand-near-head dwell detector: moving-average windows in block memories,
// running sums, dwell counters and an APB register file.
// Depends on hnhd_pkg.
//
//  channel | role   | signals                                 | word
//  s_*     | input  | s_tvalid s_tready s_tdata s_tuser       | head/hand coords, valid flag
//  m_*     | output | m_tvalid m_tready m_tdata               | detected
//  apb     | config | psel penable pwrite paddr pwdata prdata | four registers
//
// One word per cycle sustained while m_tready does not stall. Accepting a
// valid-coords word reads the oldest sample and writes the new one into each
// window memory (read-before-write on one port); as the stage register moves
// on, sums, fill counts and dwell counters update into the output register.
// Reset clears sums, counts, slots, dwell counters and registers to defaults;
// window memories are not cleared, an entry is only read back once written.
// A stall on m_tready backs up through the stage register to s_tready.
module hand_near_head_dwell_detector (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [9:0] head_x, [19:10] head_y, [29:20] hand_x, [39:30] hand_y
  input  logic [hnhd_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [0] coords_valid
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] detected, [7:1] zero
  output logic [hnhd_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hnhd_pkg::ADDR_W-1:0]        paddr,
  input  logic [hnhd_pkg::DATA_W-1:0]        pwdata,
  output logic [hnhd_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int CW = hnhd_pkg::COORD_W;

  // Configuration registers.
  logic [hnhd_pkg::LIMIT_W-1:0] x_limit, y_limit;
  logic [hnhd_pkg::HOLD_W-1:0]  x_hold, y_hold;
  hnhd_pkg::reg_idx_t           reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = hnhd_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit <= hnhd_pkg::X_LIMIT_RST;
      y_limit <= hnhd_pkg::Y_LIMIT_RST;
      x_hold  <= hnhd_pkg::X_HOLD_RST;
      y_hold  <= hnhd_pkg::Y_HOLD_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        hnhd_pkg::REG_X_LIMIT: x_limit <= pwdata[hnhd_pkg::LIMIT_W-1:0];
        hnhd_pkg::REG_Y_LIMIT: y_limit <= pwdata[hnhd_pkg::LIMIT_W-1:0];
        hnhd_pkg::REG_X_HOLD:  x_hold  <= pwdata[hnhd_pkg::HOLD_W-1:0];
        hnhd_pkg::REG_Y_HOLD:  y_hold  <= pwdata[hnhd_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      hnhd_pkg::REG_X_LIMIT: prdata = hnhd_pkg::DATA_W'(x_limit);
      hnhd_pkg::REG_Y_LIMIT: prdata = hnhd_pkg::DATA_W'(y_limit);
      hnhd_pkg::REG_X_HOLD:  prdata = hnhd_pkg::DATA_W'(x_hold);
      hnhd_pkg::REG_Y_HOLD:  prdata = hnhd_pkg::DATA_W'(y_hold);
      default:               prdata = '0;
    endcase
  end

  // Handshake and pipeline control.
  logic st_valid, st_coords;
  logic advance, in_fire, st_fire, out_fire;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !st_valid || advance;
  assign in_fire  = s_tvalid && s_tready;
  assign st_fire  = st_valid && advance;
  assign out_fire = m_tvalid && m_tready;

  // Accept stage: distances and window memory access.
  logic [CW-1:0] in_dx, in_dy;
  logic          mem_we;

  assign in_dx  = hnhd_pkg::abs_diff(s_tdata[CW-1:0], s_tdata[3*CW-1:2*CW]);
  assign in_dy  = hnhd_pkg::abs_diff(s_tdata[2*CW-1:CW], s_tdata[4*CW-1:3*CW]);
  assign mem_we = in_fire && s_tuser;

  logic [CW-1:0] x_mem [hnhd_pkg::X_WINDOW];
  logic [CW-1:0] y_mem [hnhd_pkg::Y_WINDOW];
  logic [CW-1:0] x_old, y_old;
  logic [hnhd_pkg::X_IDX_W-1:0] x_slot;
  logic [hnhd_pkg::Y_IDX_W-1:0] y_slot;

  // The read returns the sample being replaced, the one written a window ago.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      x_old         <= x_mem[x_slot];
      x_mem[x_slot] <= in_dx;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      y_old         <= y_mem[y_slot];
      y_mem[y_slot] <= in_dy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_slot <= '0;
      y_slot <= '0;
    end else if (mem_we) begin
      x_slot <= (x_slot == hnhd_pkg::X_IDX_W'(hnhd_pkg::X_WINDOW - 1)) ? '0 : x_slot + 1'b1;
      y_slot <= (y_slot == hnhd_pkg::Y_IDX_W'(hnhd_pkg::Y_WINDOW - 1)) ? '0 : y_slot + 1'b1;
    end
  end

  logic [CW-1:0] st_dx, st_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_fire) begin
      st_valid <= 1'b1;
    end else if (st_fire) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      st_coords <= s_tuser;
      st_dx     <= in_dx;
      st_dy     <= in_dy;
    end
  end

  // Update stage: running sums, fill counts, mean compares, dwell counters.
  logic [hnhd_pkg::X_SUM_W-1:0] x_sum, x_sum_next;
  logic [hnhd_pkg::Y_SUM_W-1:0] y_sum, y_sum_next;
  logic [hnhd_pkg::X_CNT_W-1:0] x_filled, x_filled_next;
  logic [hnhd_pkg::Y_CNT_W-1:0] y_filled, y_filled_next;
  logic [hnhd_pkg::X_PROD_W-1:0] x_bound;
  logic [hnhd_pkg::Y_PROD_W-1:0] y_bound;
  logic [hnhd_pkg::DWELL_W-1:0] x_dwell, x_dwell_next, y_dwell, y_dwell_next;
  logic x_full, y_full, x_below, y_below, detected_next;

  assign x_full = (x_filled == hnhd_pkg::X_CNT_W'(hnhd_pkg::X_WINDOW));
  assign y_full = (y_filled == hnhd_pkg::Y_CNT_W'(hnhd_pkg::Y_WINDOW));

  always_comb begin
    x_sum_next    = x_sum + hnhd_pkg::X_SUM_W'(st_dx)
                    - (x_full ? hnhd_pkg::X_SUM_W'(x_old) : '0);
    y_sum_next    = y_sum + hnhd_pkg::Y_SUM_W'(st_dy)
                    - (y_full ? hnhd_pkg::Y_SUM_W'(y_old) : '0);
    x_filled_next = x_full ? x_filled : x_filled + 1'b1;
    y_filled_next = y_full ? y_filled : y_filled + 1'b1;
    x_bound       = hnhd_pkg::X_PROD_W'(x_limit) * hnhd_pkg::X_PROD_W'(x_filled_next);
    y_bound       = hnhd_pkg::Y_PROD_W'(y_limit) * hnhd_pkg::Y_PROD_W'(y_filled_next);
    x_below       = hnhd_pkg::X_PROD_W'(x_sum_next) < x_bound;
    y_below       = hnhd_pkg::Y_PROD_W'(y_sum_next) < y_bound;
    x_dwell_next  = !x_below ? '0
                  : (x_dwell == hnhd_pkg::DWELL_MAX) ? x_dwell : x_dwell + 1'b1;
    y_dwell_next  = !y_below ? '0
                  : (y_dwell == hnhd_pkg::DWELL_MAX) ? y_dwell : y_dwell + 1'b1;
    detected_next = st_coords && (x_dwell_next > x_hold) && (y_dwell_next > y_hold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_sum    <= '0;
      y_sum    <= '0;
      x_filled <= '0;
      y_filled <= '0;
      x_dwell  <= '0;
      y_dwell  <= '0;
    end else if (st_fire && st_coords) begin
      x_sum    <= x_sum_next;
      y_sum    <= y_sum_next;
      x_filled <= x_filled_next;
      y_filled <= y_filled_next;
      x_dwell  <= x_dwell_next;
      y_dwell  <= y_dwell_next;
    end
  end

  // Output register.
  logic detected;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (st_fire) begin
      m_tvalid <= 1'b1;
    end else if (out_fire) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_fire) begin
      detected <= detected_next;
    end
  end

  assign m_tdata = {{(hnhd_pkg::OUT_TDATA_W-1){1'b0}}, detected};

  // Assertions.
  a_x_filled_range: assert property (@(posedge clk) disable iff (rst)
    x_filled <= hnhd_pkg::X_CNT_W'(hnhd_pkg::X_WINDOW))
    else $error("x fill count beyond window size");

  a_y_slot_range: assert property (@(posedge clk) disable iff (rst)
    y_slot <= hnhd_pkg::Y_IDX_W'(hnhd_pkg::Y_WINDOW - 1))
    else $error("y write slot beyond window");

  a_invalid_holds_sums: assert property (@(posedge clk) disable iff (rst)
    (st_fire && !st_coords) |=> ($stable(x_sum) && $stable(y_sum) && $stable(x_dwell)))
    else $error("invalid word changed window state");

  a_detect_needs_dwell: assert property (@(posedge clk) disable iff (rst)
    (st_fire && detected_next) |=> (x_dwell > x_hold && y_dwell > y_hold))
    else $error("detected without both dwell counts");

  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (st_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("word accepted while stage is blocked");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench for hand_near_head_dwell_detector: a scoreboard class predicts the
// detected flag per frame, plain tasks drive the stream and APB ports.
// Depends on hnhd_pkg and the detector RTL.
module tb;
  import hnhd_pkg::*;

  localparam int COORD_MAX      = (1 << COORD_W) - 1;
  localparam int HIST_D         = (X_WINDOW > Y_WINDOW) ? X_WINDOW : Y_WINDOW;
  localparam int AX_X           = 0;
  localparam int AX_Y           = 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;

  // Predicts the detected flag for every frame word and keeps the flags that
  // are still to come out of the block.
  class detect_scoreboard;
    logic [LIMIT_W-1:0] x_limit = X_LIMIT_RST;
    logic [LIMIT_W-1:0] y_limit = Y_LIMIT_RST;
    logic [HOLD_W-1:0]  x_hold  = X_HOLD_RST;
    logic [HOLD_W-1:0]  y_hold  = Y_HOLD_RST;
    logic [COORD_W-1:0] hist [2][HIST_D];
    int unsigned        depth [2];
    int unsigned        total [2];
    int unsigned        filled [2];
    int unsigned        slot [2];
    int unsigned        dwell [2];
    bit                 pending_detect [$];
    int                 errors;
    int                 frames;
    int                 valid_frames;
    int                 detections;
    int                 reg_writes;

    function new();
      depth[AX_X] = X_WINDOW;
      depth[AX_Y] = Y_WINDOW;
    endfunction

    function void set_register(reg_idx_t idx, logic [DATA_W-1:0] value);
      reg_writes++;
      case (idx)
        REG_X_LIMIT: x_limit = value[LIMIT_W-1:0];
        REG_Y_LIMIT: y_limit = value[LIMIT_W-1:0];
        REG_X_HOLD:  x_hold  = value[HOLD_W-1:0];
        REG_Y_HOLD:  y_hold  = value[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] reg_value(reg_idx_t idx);
      case (idx)
        REG_X_LIMIT: return DATA_W'(x_limit);
        REG_Y_LIMIT: return DATA_W'(y_limit);
        REG_X_HOLD:  return DATA_W'(x_hold);
        default:     return DATA_W'(y_hold);
      endcase
    endfunction

    function int unsigned distance(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // The oldest entry is only retired once the window is full, so an
    // unwritten slot is never read.
    function bit push_distance(int axis, int unsigned gap_px, int unsigned limit);
      if (filled[axis] >= depth[axis])
        total[axis] -= hist[axis][slot[axis]];
      else
        filled[axis]++;
      hist[axis][slot[axis]] = COORD_W'(gap_px);
      total[axis] += gap_px;
      slot[axis] = (slot[axis] + 1 == depth[axis]) ? 0 : slot[axis] + 1;
      return total[axis] < limit * filled[axis];
    endfunction

    function void note_frame(logic coords_ok, logic [IN_TDATA_W-1:0] word);
      logic [COORD_W-1:0] head_x, head_y, hand_x, hand_y;
      bit                 below [2];
      bit                 det;
      head_x = word[0 +: COORD_W];
      head_y = word[COORD_W +: COORD_W];
      hand_x = word[2*COORD_W +: COORD_W];
      hand_y = word[3*COORD_W +: COORD_W];
      frames++;
      det = 1'b0;
      if (coords_ok) begin
        valid_frames++;
        below[AX_X] = push_distance(AX_X, distance(head_x, hand_x), x_limit);
        below[AX_Y] = push_distance(AX_Y, distance(head_y, hand_y), y_limit);
        for (int a = 0; a < 2; a++)
          dwell[a] = !below[a] ? 0 : (dwell[a] < DWELL_MAX) ? dwell[a] + 1 : DWELL_MAX;
        det = (dwell[AX_X] > x_hold) && (dwell[AX_Y] > y_hold);
      end
      pending_detect.push_back(det);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word);
      bit want;
      if (pending_detect.size() == 0) begin
        errors++;
        $display("%0t: result word %h with no frame pending", $time, word);
        return;
      end
      want = pending_detect.pop_front();
      if (word[0] === 1'b1)
        detections++;
      if (word[0] !== want) begin
        errors++;
        $display("%0t: detected mismatch, expected %0d, actual %b", $time, want, word[0]);
      end
      if (word[OUT_TDATA_W-1:1] !== '0) begin
        errors++;
        $display("%0t: padding mismatch, expected 0, actual %b", $time,
                 word[OUT_TDATA_W-1:1]);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // [9:0] head_x, [19:10] head_y, [29:20] hand_x, [39:30] hand_y
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  // [0] coords_valid
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // [0] detected, [7:1] zero
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  detect_scoreboard sb = new();
  int unsigned      src_idle_pct;
  int unsigned      sink_stall_pct;
  int               idle_cycles;

  hand_near_head_dwell_detector u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_frame(s_tuser, s_tdata);
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // All driving tasks start and end at a falling edge.
  task automatic send_frame(input logic coords_ok, input logic [COORD_W-1:0] head_x,
                            input logic [COORD_W-1:0] head_y,
                            input logic [COORD_W-1:0] hand_x,
                            input logic [COORD_W-1:0] hand_y);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {hand_y, hand_x, head_y, head_x};
    s_tuser  = coords_ok;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (sb.pending_detect.size() != 0)
      @(negedge clk);
  endtask

  // Write, then read back through the same port.
  task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] readback;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (readback !== sb.reg_value(idx)) begin
      sb.errors++;
      $display("%0t: register %s readback, expected %h, actual %h", $time, idx.name(),
               sb.reg_value(idx), readback);
    end
  endtask

  // Upper bits of pwdata carry junk that the block must drop.
  task automatic configure(input int unsigned xl, input int unsigned yl,
                           input int unsigned xh, input int unsigned yh);
    wait_drained();
    reg_write(REG_X_LIMIT, DATA_W'(xl) | ($urandom << LIMIT_W));
    reg_write(REG_Y_LIMIT, DATA_W'(yl) | ($urandom << LIMIT_W));
    reg_write(REG_X_HOLD,  DATA_W'(xh) | ($urandom << HOLD_W));
    reg_write(REG_Y_HOLD,  DATA_W'(yh) | ($urandom << HOLD_W));
  endtask

  function automatic logic [COORD_W-1:0] near_to(input logic [COORD_W-1:0] c,
                                                 input int unsigned d);
    int unsigned base;
    base = c;
    if ($urandom_range(1) && base + d <= COORD_MAX)
      return COORD_W'(base + d);
    if (base >= d)
      return COORD_W'(base - d);
    return (base + d > COORD_MAX) ? COORD_W'(COORD_MAX) : COORD_W'(base + d);
  endfunction

  // Mostly hands held near the head at distances around the current limits,
  // broken by invalid frames and far-apart noise.
  task automatic random_frames(input int count);
    int unsigned        roll, span_x, span_y;
    logic [COORD_W-1:0] head_x, head_y;
    span_x = sb.x_limit + sb.x_limit / 2 + 1;
    span_y = sb.y_limit + sb.y_limit / 2 + 1;
    if (span_x > COORD_MAX) span_x = COORD_MAX;
    if (span_y > COORD_MAX) span_y = COORD_MAX;
    for (int i = 0; i < count; i++) begin
      roll   = $urandom_range(99);
      head_x = COORD_W'($urandom);
      head_y = COORD_W'($urandom);
      if (roll < 8)
        send_frame(1'b0, head_x, head_y, COORD_W'($urandom), COORD_W'($urandom));
      else if (roll < 16)
        send_frame(1'b1, head_x, head_y, COORD_W'($urandom), COORD_W'($urandom));
      else
        send_frame(1'b1, head_x, head_y, near_to(head_x, $urandom_range(span_x)),
                   near_to(head_y, $urandom_range(span_y)));
      if ($urandom_range(79) == 0)
        wait_drained();
    end
  endtask

  initial begin
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    idle_cycles    = 0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Default settings: an invalid frame, zero distance, a held pose long
    // enough to detect, an invalid frame that must leave the state alone,
    // full-scale distances both ways and a distance exactly at the limit.
    send_frame(1'b0, '1, '1, '1, '1);
    send_frame(1'b1, '0, '0, '0, '0);
    repeat (12) send_frame(1'b1, 10'd100, 10'd900, 10'd103, 10'd897);
    send_frame(1'b0, '0, '0, '1, '1);
    send_frame(1'b1, 10'd100, 10'd900, 10'd103, 10'd897);
    send_frame(1'b1, '1, '1, '0, '0);
    send_frame(1'b1, '0, '0, '1, '1);
    send_frame(1'b1, 10'd512, 10'd512, 10'd542, 10'd482);

    configure(30, 30, 5, 10);
    random_frames(100);

    // Widest limits with a hold of 254: the dwell counters saturate.
    src_idle_pct = 59;
    configure(COORD_MAX, COORD_MAX, 254, 254);
    random_frames(280);

    // Zero limit keeps x cleared; a hold of 255 can never be exceeded.
    src_idle_pct   = 0;
    sink_stall_pct = 59;
    configure(0, 40, 0, 255);
    random_frames(120);

    src_idle_pct   = 10;
    sink_stall_pct = 10;
    configure($urandom_range(5, 80), $urandom_range(5, 80), 0, $urandom_range(20));
    random_frames(70);
    configure($urandom_range(5, 80), $urandom_range(5, 80), $urandom_range(20), 0);
    random_frames(70);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d frames (%0d with usable coordinates), %0d detections,",
             sb.frames, sb.valid_frames, sb.detections);
    $display("%0d register writes, under four source-idle and sink-stall mixes.",
             sb.reg_writes);
    if (sb.errors == 0 && sb.pending_detect.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/hnhd_pkg.sv
hdl/hand_near_head_dwell_detector.sv
test/tb.sv
